// ===== rtl/assert_macros.svh =====
// assertion macros shared by the deframer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while rst_n is low
`define SHFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define SHFD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/shfd_pkg.sv =====
// package: constants, codes and types of the sync header frame deframer
`default_nettype none

package shfd_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned FRAME_BYTES   = 9;
  localparam int unsigned HEADER_BYTES  = 3;
  localparam int unsigned PAYLOAD_BYTES = FRAME_BYTES - HEADER_BYTES;
  localparam int unsigned SHIFT_W       = PAYLOAD_BYTES * BYTE_W;
  localparam int unsigned CNT_W         = $clog2(PAYLOAD_BYTES + 1);
  localparam int unsigned TICK_W        = 32;
  localparam int unsigned VALUE_W       = 16;
  localparam int unsigned CFG_IDX_W     = 2;

  // reset values of the header bytes
  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'hBB;
  localparam logic [BYTE_W-1:0] SYNC_THIRD_RST  = 8'hCC;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_THIRD  = 2'd2;

  // header bytes as seen by the parser
  typedef struct packed {
    logic [BYTE_W-1:0] first;
    logic [BYTE_W-1:0] second;
    logic [BYTE_W-1:0] third;
  } shfd_sync_t;

  // registered input byte handed to the parser
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } shfd_byte_t;

endpackage

`default_nettype wire

// ===== rtl/shfd_ifs.sv =====
// channel interfaces: input bytes, result frames, configuration writes
`default_nettype none

interface shfd_byte_if import shfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface shfd_frame_if import shfd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [TICK_W-1:0]         frame_tick;
  logic signed [VALUE_W-1:0] frame_value;

  modport source (output valid, output frame_tick, output frame_value, input ready);
  modport sink   (input valid, input frame_tick, input frame_value, output ready);
endinterface

interface shfd_cfg_if import shfd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/shfd_cfg_regs.sv =====
// header byte configuration registers
`default_nettype none

module shfd_cfg_regs import shfd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_valid,
  output logic                      wr_ready,
  input  wire logic [CFG_IDX_W-1:0] wr_index,
  input  wire logic [BYTE_W-1:0]    wr_data,
  output shfd_sync_t                sync
);

  shfd_sync_t sync_r;
  shfd_sync_t sync_nxt;

  assign wr_ready = 1'b1;
  assign sync     = sync_r;

  // decode the register index, unknown indexes are dropped
  always_comb begin
    sync_nxt = sync_r;
    if (wr_valid) begin
      case (wr_index)
        CFG_SYNC_FIRST:  sync_nxt.first  = wr_data;
        CFG_SYNC_SECOND: sync_nxt.second = wr_data;
        CFG_SYNC_THIRD:  sync_nxt.third  = wr_data;
        default:         sync_nxt        = sync_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r.first  <= SYNC_FIRST_RST;
      sync_r.second <= SYNC_SECOND_RST;
      sync_r.third  <= SYNC_THIRD_RST;
    end else begin
      sync_r <= sync_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/shfd_in_stage.sv =====
// input register stage for received bytes
`default_nettype none
`include "assert_macros.svh"

module shfd_in_stage import shfd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BYTE_W-1:0] in_data,
  input  wire logic              advance,
  output shfd_byte_t             held
);

  logic              valid_r;
  logic [BYTE_W-1:0] byte_r;

  // take a new item when empty or when the held one moves on
  assign in_ready   = !valid_r || advance;
  assign held.valid = valid_r;
  assign held.data  = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // payload byte, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_data;
    end
  end

  `SHFD_ASSERT(a_hold_when_stalled, (valid_r && !advance) |=> (valid_r && $stable(byte_r)), "held byte lost while stalled")

endmodule

`default_nettype wire

// ===== rtl/shfd_parser.sv =====
// header hunt, payload collect and result register
`default_nettype none
`include "assert_macros.svh"

module shfd_parser import shfd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire shfd_byte_t           held,
  input  wire shfd_sync_t           sync,
  output logic                      advance,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [TICK_W-1:0]         out_tick,
  output logic signed [VALUE_W-1:0] out_value
);

  typedef enum logic [1:0] {
    PH_FIRST   = 2'd0,
    PH_SECOND  = 2'd1,
    PH_THIRD   = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  phase_t                    phase_r, phase_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [SHIFT_W-1:0]        shift_r, shift_nxt;
  logic                      done;
  logic                      out_valid_r;
  logic [TICK_W-1:0]         tick_r;
  logic signed [VALUE_W-1:0] value_r;

  // the held item moves on whenever the result register can take a result
  assign advance   = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_tick  = tick_r;
  assign out_value = value_r;

  // next state for one byte
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    shift_nxt = shift_r;
    done      = 1'b0;
    case (phase_r)
      PH_FIRST: begin
        if (held.data == sync.first) phase_nxt = PH_SECOND;
      end
      PH_SECOND: begin
        if (held.data == sync.second) begin
          phase_nxt = PH_THIRD;
        end else begin
          phase_nxt = PH_FIRST;
          count_nxt = '0;
        end
      end
      PH_THIRD: begin
        phase_nxt = (held.data == sync.third) ? PH_PAYLOAD : PH_FIRST;
        count_nxt = '0;
      end
      PH_PAYLOAD: begin
        shift_nxt = {shift_r[SHIFT_W-BYTE_W-1:0], held.data};
        count_nxt = count_r + CNT_W'(1);
        if (count_r == CNT_W'(PAYLOAD_BYTES - 1)) begin
          done      = 1'b1;
          phase_nxt = PH_FIRST;
          count_nxt = '0;
        end
      end
      default: phase_nxt = PH_FIRST;
    endcase
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FIRST;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= held.valid && done;
      if (held.valid) begin
        phase_r <= phase_nxt;
        count_r <= count_nxt;
      end
    end
  end

  // payload shift and result fields
  always_ff @(posedge clk) begin
    if (advance && held.valid) begin
      shift_r <= shift_nxt;
      if (done) begin
        tick_r  <= shift_nxt[SHIFT_W-1 -: TICK_W];
        value_r <= $signed(shift_nxt[VALUE_W-1:0]);
      end
    end
  end

  `SHFD_ASSERT(a_result_after_payload, $rose(out_valid_r) |-> ($past(phase_r) == PH_PAYLOAD), "result without payload phase")
  `SHFD_ASSERT(a_count_in_range, (phase_r == PH_PAYLOAD) |-> (count_r < CNT_W'(PAYLOAD_BYTES)), "payload count overrun")
  `SHFD_ASSERT(a_count_idle_zero, (phase_r != PH_PAYLOAD) |-> (count_r == '0), "count not cleared while hunting")

endmodule

`default_nettype wire

// ===== rtl/sync_header_frame_deframer.sv =====
// top level of the sync header frame deframer
//
// Bytes arrive on in_bus (valid/ready, one rx_byte per item). The block hunts
// for three header bytes, set by the cfg_bus registers (index 0, 1, 2; reset
// 0xAA, 0xBB, 0xCC), then collects six payload bytes big-endian. After the
// sixth it sends one item on out_bus: frame_tick from payload bytes one to
// four and the signed frame_value from bytes five and six. A wrong second or
// third header byte sends it back to hunting and is not tried as a first byte.
// One byte is taken every cycle while out_bus does not stall; a result passes
// through the input register, then the result register, before it leaves.
// When out_bus stalls, the held result stays and one more byte waits in the
// input register; in_bus ready falls only when both are full.
// Synchronous reset on rst_n clears the hunt state, empties both registers
// and restores the header bytes. cfg_bus is always ready; write it only while
// the block is idle.
`default_nettype none

module sync_header_frame_deframer import shfd_pkg::*; (
  input wire logic   clk,
  input wire logic   rst_n,
  shfd_byte_if.sink  in_bus,
  shfd_frame_if.source out_bus,
  shfd_cfg_if.sink   cfg_bus
);

  shfd_sync_t sync;
  shfd_byte_t held;
  logic       advance;

  // header registers
  shfd_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cfg_bus.valid),
    .wr_ready (cfg_bus.ready),
    .wr_index (cfg_bus.index),
    .wr_data  (cfg_bus.data),
    .sync     (sync)
  );

  // input register
  shfd_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .in_data  (in_bus.rx_byte),
    .advance  (advance),
    .held     (held)
  );

  // frame parser and result register
  shfd_parser u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .held      (held),
    .sync      (sync),
    .advance   (advance),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_tick  (out_bus.frame_tick),
    .out_value (out_bus.frame_value)
  );

endmodule

`default_nettype wire

// ===== test/shfd_frame_checker.sv =====
// frame checker: predicts deframer results from the watched channels and compares them
`default_nettype none

module shfd_frame_checker import shfd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  shfd_byte_if      in_mon,
  shfd_frame_if     out_mon,
  shfd_cfg_if       cfg_mon,
  output int        fail_count,
  output int        expected_left
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    HUNT_FIRST,
    HUNT_SECOND,
    HUNT_THIRD,
    HUNT_PAYLOAD
  } hunt_t;

  typedef struct packed {
    logic [TICK_W-1:0]         tick;
    logic signed [VALUE_W-1:0] value;
  } frame_t;

  // own copy of the header registers and the hunt state
  shfd_sync_t         hdr;
  hunt_t              hunt;
  logic [CNT_W-1:0]   payload_taken;
  logic [SHIFT_W-1:0] payload_bits;
  frame_t             frames_due[$];

  initial begin
    fail_count    = 0;
    expected_left = 0;
  end

  task automatic report(input string what);
    $display("%0t ns  deframer mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  // advance the hunt by one received byte, queue a frame when one completes
  function automatic void take_byte(input logic [BYTE_W-1:0] b);
    case (hunt)
      HUNT_FIRST: begin
        if (b == hdr.first) hunt = HUNT_SECOND;
      end
      HUNT_SECOND: begin
        if (b == hdr.second) begin
          hunt = HUNT_THIRD;
        end else begin
          hunt          = HUNT_FIRST;
          payload_taken = '0;
        end
      end
      HUNT_THIRD: begin
        hunt          = (b == hdr.third) ? HUNT_PAYLOAD : HUNT_FIRST;
        payload_taken = '0;
      end
      default: begin
        payload_bits  = {payload_bits[SHIFT_W-BYTE_W-1:0], b};
        payload_taken = payload_taken + 1'b1;
        if (payload_taken >= PAYLOAD_BYTES) begin
          frames_due.push_back({payload_bits[SHIFT_W-1:VALUE_W],
                                payload_bits[VALUE_W-1:0]});
          hunt          = HUNT_FIRST;
          payload_taken = '0;
        end
      end
    endcase
  endfunction

  // watch all three channels at each edge
  always @(posedge clk) begin
    frame_t want;
    if (!rst_n) begin
      hdr           = '{first: SYNC_FIRST_RST, second: SYNC_SECOND_RST,
                        third: SYNC_THIRD_RST};
      hunt          = HUNT_FIRST;
      payload_taken = '0;
      payload_bits  = '0;
      frames_due.delete();
    end else begin
      // compare a leaving frame with the oldest one due
      if (out_mon.valid && out_mon.ready) begin
        if (frames_due.size() == 0) begin
          report($sformatf("frame tick %h value %0d with no frame due",
                           out_mon.frame_tick, out_mon.frame_value));
        end else begin
          want = frames_due.pop_front();
          if (out_mon.frame_tick !== want.tick)
            report($sformatf("frame_tick got %h want %h", out_mon.frame_tick, want.tick));
          if (out_mon.frame_value !== want.value)
            report($sformatf("frame_value got %0d want %0d",
                             out_mon.frame_value, want.value));
        end
      end
      // header register writes, spare index ignored
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_SYNC_FIRST:  hdr.first  = cfg_mon.data;
          CFG_SYNC_SECOND: hdr.second = cfg_mon.data;
          CFG_SYNC_THIRD:  hdr.third  = cfg_mon.data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) take_byte(in_mon.rx_byte);
    end
    expected_left = frames_due.size();
  end

endmodule

`default_nettype wire

// ===== test/tb_sync_header_frame_deframer.sv =====
// testbench top: byte stimulus, header settings, stall pattern and verdict for the deframer
`default_nettype none

module tb_sync_header_frame_deframer import shfd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int TRAFFIC_ITEMS = 188;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   expected_left;

  shfd_byte_if  in_bus ();
  shfd_frame_if out_bus ();
  shfd_cfg_if   cfg_bus ();

  sync_header_frame_deframer dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  shfd_frame_checker frame_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_bus),
    .out_mon       (out_bus),
    .cfg_mon       (cfg_bus),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  // header now in the registers, used to build frames
  shfd_sync_t hdr_now;
  int         burst_left;
  int         sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("FAIL sync_header_frame_deframer");
    $finish;
  end

  // receiver ready follows a 16-bit stall pattern that is redrawn at random
  initial begin
    logic [15:0] stall_map;
    int          step;
    out_bus.ready = 1'b0;
    stall_map     = '1;
    step          = 0;
    forever begin
      @(posedge clk);
      if (step % 48 == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_map = '1;
          1:       stall_map = 16'($urandom);
          2:       stall_map = 16'($urandom & $urandom);
          default: stall_map = 16'($urandom | $urandom);
        endcase
      end
      out_bus.ready <= stall_map[step % 16];
      step++;
    end
  end

  // one byte item, sent in bursts with random gaps
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_bus.valid   <= 1'b1;
    in_bus.rx_byte <= b;
    do @(posedge clk); while (!in_bus.ready);
    burst_left--;
    sent++;
  endtask

  // hold the sender until every frame has left, then let the pipeline settle
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    burst_left = 0;
  endtask

  // one register write, valid left high for the next one
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
  endtask

  // write all three header bytes and a write to the unused index
  task automatic write_header(input logic [BYTE_W-1:0] a, b, c);
    put_reg(CFG_SYNC_FIRST, a);
    put_reg(CFG_SPARE, 8'($urandom));
    put_reg(CFG_SYNC_SECOND, b);
    put_reg(CFG_SYNC_THIRD, c);
    cfg_bus.valid <= 1'b0;
    hdr_now = '{first: a, second: b, third: c};
  endtask

  // full frame: header then payload most significant byte first
  task automatic send_frame(input logic [SHIFT_W-1:0] payload);
    send_byte(hdr_now.first);
    send_byte(hdr_now.second);
    send_byte(hdr_now.third);
    for (int i = PAYLOAD_BYTES - 1; i >= 0; i--) send_byte(payload[i*BYTE_W +: BYTE_W]);
  endtask

  // byte biased toward extremes and header values
  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return hdr_now.first;
      3:       return hdr_now.second;
      4:       return hdr_now.third;
      default: return 8'($urandom);
    endcase
  endfunction

  // mostly good frames, some broken headers and loose bytes
  task automatic run_traffic(input int count);
    int                 stop_at;
    int                 roll;
    logic [SHIFT_W-1:0] payload;
    stop_at = sent + count;
    while (sent < stop_at) begin
      roll = $urandom_range(0, 99);
      if (roll < 72) begin
        for (int i = 0; i < PAYLOAD_BYTES; i++) payload[i*BYTE_W +: BYTE_W] = pick_byte();
        send_frame(payload);
      end else if (roll < 84) begin
        send_byte(hdr_now.first);
        if ($urandom_range(0, 1) == 1) send_byte(hdr_now.second);
        send_byte(pick_byte());
      end else begin
        send_byte(pick_byte());
      end
      if ($urandom_range(0, 199) == 0) wait_idle();
    end
    wait_idle();
  endtask

  initial begin
    logic [BYTE_W-1:0] shared;
    in_bus.valid   = 1'b0;
    in_bus.rx_byte = '0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.index  = CFG_SYNC_FIRST;
    cfg_bus.data   = '0;
    rst_n          = 1'b0;
    burst_left     = 0;
    sent           = 0;
    hdr_now        = '{first: SYNC_FIRST_RST, second: SYNC_SECOND_RST,
                       third: SYNC_THIRD_RST};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset header values written back, then the corner cases
    write_header(SYNC_FIRST_RST, SYNC_SECOND_RST, SYNC_THIRD_RST);
    send_byte(8'h00);                 // first byte mismatch at both extremes
    send_byte(8'hFF);
    send_byte(hdr_now.first);         // wrong second byte
    send_byte(8'h00);
    send_byte(hdr_now.first);         // wrong third byte equal to first, dropped
    send_byte(hdr_now.second);
    send_byte(hdr_now.first);
    send_frame({32'hFFFF_FFFF, 16'h8000});
    send_frame({32'h0000_0000, 16'h7FFF});
    wait_idle();

    // random traffic across header settings
    run_traffic(TRAFFIC_ITEMS);
    write_header(8'h00, 8'h00, 8'h00);
    run_traffic(TRAFFIC_ITEMS);
    write_header(8'hFF, 8'hFF, 8'hFF);
    run_traffic(TRAFFIC_ITEMS);
    write_header(8'h00, 8'hFF, 8'h00);
    run_traffic(TRAFFIC_ITEMS);
    shared = 8'($urandom);
    write_header(shared, shared, 8'($urandom));
    run_traffic(TRAFFIC_ITEMS);
    write_header(8'($urandom), 8'($urandom), 8'($urandom));
    run_traffic(TRAFFIC_ITEMS);

    // final settle and verdict
    repeat (4) @(posedge clk);
    if (fail_count == 0 && expected_left == 0) begin
      $display("PASS sync_header_frame_deframer");
    end else begin
      $display("FAIL sync_header_frame_deframer");
    end
    $finish;
  end

endmodule

`default_nettype wire
